@@ rtl/core/assert_macros.svh @@
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define AHAP_ASSERT_IMP(lbl, clk, rstn, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (pre) |-> (post)) \
    else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define AHAP_ASSERT_NXT(lbl, clk, rstn, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (pre) |=> (post)) \
    else $error("assertion failed");

`endif

@@ rtl/core/ahap_pkg.sv @@
// Package: types, widths and constants of the attention head anomaly probe.
package ahap_pkg;

  localparam int MAX_HEAD_ELEMENTS = 65536;
  localparam int Q_ONE             = 32768;

  localparam int WGT_W   = 16;
  localparam int LAYER_W = 8;
  localparam int HEAD_W  = 6;
  localparam int KIND_W  = 2;
  localparam int TOT_W   = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // element count must hold MAX_HEAD_ELEMENTS itself
  localparam int CNT_W  = $clog2(MAX_HEAD_ELEMENTS + 1);
  localparam int SUM_W  = $clog2(longint'(MAX_HEAD_ELEMENTS) * Q_ONE + 1);
  // mean never exceeds Q_ONE, so the quotient fits in one weight word
  localparam int QUO_W  = WGT_W;
  localparam int STEP_W = $clog2(QUO_W);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MAX_LIMIT   = 2'd0,
    CFG_MEAN_LIMIT  = 2'd1,
    CFG_FIRST_LAYER = 2'd2,
    CFG_LAST_LAYER  = 2'd3
  } cfg_idx_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_NORMAL = 2'd0,
    KIND_MAX    = 2'd1,
    KIND_MEAN   = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    ST_ACC,
    ST_DLOAD,
    ST_DIV,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic acc_en;     // accumulate the accepted weight word
    logic clr_stats;  // clear probed and anomaly counters
    logic div_load;   // load divider from sum and count
    logic div_step;   // one restoring division step
    logic out_load;   // capture result, bump counters, restart head
  } ctrl_cmd_t;

  typedef struct packed {
    logic hit;        // weight word in probed layer range
    logic clr;        // clear action on the input
    logic last;       // head end flag on the input
    logic out_busy;   // output register full and stalled
  } dp_stat_t;

endpackage

@@ rtl/core/attention_head_anomaly_probe.sv @@
// Top level of the attention head anomaly probe.
//
//  channel | direction | handshake            | word
//  in_     | input     | in_valid / in_stall  | action, weight, layer, head, head end
//  out_    | output    | out_valid / out_stall| tags, peak, mean, kind, two totals
//  cfg_    | input     | cfg_valid / cfg_ready| register index, data
//
// Weight words and clear actions stream back-to-back at one per cycle while no probed head end is in progress.
// A probed head-end word stalls the input through load, 16 steps of the bit-serial divider, and hand-off.
// The result sits in an output register; new words are taken while it waits,
// but the next head end stalls at hand-off until out_stall drops.
// Synchronous active-low reset; no clearing pass, the block is ready right after reset.
module attention_head_anomaly_probe (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic                            in_action,
  input  logic [ahap_pkg::WGT_W-1:0]      in_weight,
  input  logic [ahap_pkg::LAYER_W-1:0]    in_layer_index,
  input  logic [ahap_pkg::HEAD_W-1:0]     in_head_index,
  input  logic                            in_head_end,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [ahap_pkg::LAYER_W-1:0]    out_layer,
  output logic [ahap_pkg::HEAD_W-1:0]     out_head,
  output logic [ahap_pkg::WGT_W-1:0]      out_peak_weight,
  output logic [ahap_pkg::WGT_W-1:0]      out_average_weight,
  output logic [ahap_pkg::KIND_W-1:0]     out_anomaly_kind,
  output logic [ahap_pkg::TOT_W-1:0]      out_probed_total,
  output logic [ahap_pkg::TOT_W-1:0]      out_anomaly_total,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [ahap_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ahap_pkg::CFG_DATA_W-1:0] cfg_data
);

  ahap_pkg::ctrl_cmd_t cmd;
  ahap_pkg::dp_stat_t  stat;

  assign cfg_ready = 1'b1;

  ahap_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  ahap_dp u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .stat               (stat),
    .cfg_we             (cfg_valid && cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .in_action          (in_action),
    .in_weight          (in_weight),
    .in_layer_index     (in_layer_index),
    .in_head_index      (in_head_index),
    .in_head_end        (in_head_end),
    .out_stall          (out_stall),
    .out_valid          (out_valid),
    .out_layer          (out_layer),
    .out_head           (out_head),
    .out_peak_weight    (out_peak_weight),
    .out_average_weight (out_average_weight),
    .out_anomaly_kind   (out_anomaly_kind),
    .out_probed_total   (out_probed_total),
    .out_anomaly_total  (out_anomaly_total)
  );

endmodule

@@ rtl/core/ahap_div.sv @@
// Iterative restoring divider: one quotient bit per step.
module ahap_div (
  input  logic                     clk,
  input  logic                     load,
  input  logic                     step,
  input  logic [ahap_pkg::SUM_W-1:0] dividend,
  input  logic [ahap_pkg::CNT_W-1:0] divisor,
  output logic [ahap_pkg::QUO_W-1:0] quotient
);

  logic [ahap_pkg::CNT_W-1:0] rem_r, rem_nxt;
  logic [ahap_pkg::CNT_W-1:0] dvs_r, dvs_nxt;
  logic [ahap_pkg::QUO_W-1:0] low_r, low_nxt;
  logic [ahap_pkg::QUO_W-1:0] quo_r, quo_nxt;
  logic [ahap_pkg::CNT_W:0]   trial;
  logic [ahap_pkg::CNT_W:0]   diff;

  assign trial = {rem_r, low_r[ahap_pkg::QUO_W-1]};
  assign diff  = trial - {1'b0, dvs_r};

  always_comb begin
    rem_nxt = rem_r;
    dvs_nxt = dvs_r;
    low_nxt = low_r;
    quo_nxt = quo_r;
    if (load) begin
      // high part is below the divisor since the quotient fits QUO_W bits
      rem_nxt = ahap_pkg::CNT_W'(dividend[ahap_pkg::SUM_W-1:ahap_pkg::QUO_W]);
      dvs_nxt = divisor;
      low_nxt = dividend[ahap_pkg::QUO_W-1:0];
      quo_nxt = '0;
    end else if (step) begin
      low_nxt = {low_r[ahap_pkg::QUO_W-2:0], 1'b0};
      if (trial >= {1'b0, dvs_r}) begin
        rem_nxt = diff[ahap_pkg::CNT_W-1:0];
        quo_nxt = {quo_r[ahap_pkg::QUO_W-2:0], 1'b1};
      end else begin
        rem_nxt = trial[ahap_pkg::CNT_W-1:0];
        quo_nxt = {quo_r[ahap_pkg::QUO_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
    low_r <= low_nxt;
    quo_r <= quo_nxt;
  end

  assign quotient = quo_r;

endmodule

@@ rtl/core/ahap_ctrl.sv @@
// Controller: sequences accumulate, divide and result hand-off.
module ahap_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  ahap_pkg::dp_stat_t   stat,
  output ahap_pkg::ctrl_cmd_t  cmd
);

  ahap_pkg::state_t            state_r, state_nxt;
  logic [ahap_pkg::STEP_W-1:0] step_r, step_nxt;
  logic                        accept;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ahap_pkg::ST_ACC;
      step_r  <= '0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
    end
  end

  assign accept = in_valid && !in_stall;

  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    in_stall  = 1'b1;
    cmd       = '0;
    case (state_r)
      ahap_pkg::ST_ACC: begin
        in_stall      = 1'b0;
        cmd.acc_en    = accept && stat.hit;
        cmd.clr_stats = accept && stat.clr;
        if (accept && stat.hit && stat.last) begin
          state_nxt = ahap_pkg::ST_DLOAD;
        end
      end
      ahap_pkg::ST_DLOAD: begin
        cmd.div_load = 1'b1;
        step_nxt     = '0;
        state_nxt    = ahap_pkg::ST_DIV;
      end
      ahap_pkg::ST_DIV: begin
        cmd.div_step = 1'b1;
        step_nxt     = step_r + 1'b1;
        if (step_r == ahap_pkg::STEP_W'(ahap_pkg::QUO_W - 1)) begin
          state_nxt = ahap_pkg::ST_DONE;
        end
      end
      ahap_pkg::ST_DONE: begin
        if (!stat.out_busy) begin
          cmd.out_load = 1'b1;
          state_nxt    = ahap_pkg::ST_ACC;
        end
      end
      default: begin
        state_nxt = ahap_pkg::ST_ACC;
      end
    endcase
  end

endmodule

@@ rtl/core/ahap_dp.sv @@
// Datapath: config registers, head accumulators, counters, output register.
module ahap_dp (
  input  logic                          clk,
  input  logic                          rst_n,
  input  ahap_pkg::ctrl_cmd_t           cmd,
  output ahap_pkg::dp_stat_t            stat,
  input  logic                          cfg_we,
  input  logic [ahap_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ahap_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                          in_action,
  input  logic [ahap_pkg::WGT_W-1:0]    in_weight,
  input  logic [ahap_pkg::LAYER_W-1:0]  in_layer_index,
  input  logic [ahap_pkg::HEAD_W-1:0]   in_head_index,
  input  logic                          in_head_end,
  input  logic                          out_stall,
  output logic                          out_valid,
  output logic [ahap_pkg::LAYER_W-1:0]  out_layer,
  output logic [ahap_pkg::HEAD_W-1:0]   out_head,
  output logic [ahap_pkg::WGT_W-1:0]    out_peak_weight,
  output logic [ahap_pkg::WGT_W-1:0]    out_average_weight,
  output logic [ahap_pkg::KIND_W-1:0]   out_anomaly_kind,
  output logic [ahap_pkg::TOT_W-1:0]    out_probed_total,
  output logic [ahap_pkg::TOT_W-1:0]    out_anomaly_total
);

  logic [ahap_pkg::WGT_W-1:0]   max_limit_r, mean_limit_r;
  logic [ahap_pkg::LAYER_W-1:0] first_layer_r, last_layer_r;

  logic [ahap_pkg::WGT_W-1:0]   peak_r, peak_nxt;
  logic [ahap_pkg::SUM_W-1:0]   sum_r, sum_nxt;
  logic [ahap_pkg::CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [ahap_pkg::LAYER_W-1:0] tag_layer_r;
  logic [ahap_pkg::HEAD_W-1:0]  tag_head_r;
  logic [ahap_pkg::TOT_W-1:0]   probed_r, probed_nxt;
  logic [ahap_pkg::TOT_W-1:0]   anom_r, anom_nxt;
  logic                         out_valid_r, out_valid_nxt;

  logic [ahap_pkg::WGT_W-1:0]   wclip;
  logic [ahap_pkg::QUO_W-1:0]   quotient;
  ahap_pkg::kind_t              kind;

  assign stat.hit      = !in_action && (in_layer_index >= first_layer_r)
                         && (in_layer_index <= last_layer_r);
  assign stat.clr      = in_action;
  assign stat.last     = in_head_end;
  assign stat.out_busy = out_valid_r && out_stall;

  assign wclip = (in_weight > ahap_pkg::WGT_W'(ahap_pkg::Q_ONE)) ?
                 ahap_pkg::WGT_W'(ahap_pkg::Q_ONE) : in_weight;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_limit_r   <= 16'd31130;
      mean_limit_r  <= 16'd26214;
      first_layer_r <= '0;
      last_layer_r  <= '1;
    end else if (cfg_we) begin
      case (ahap_pkg::cfg_idx_t'(cfg_index))
        ahap_pkg::CFG_MAX_LIMIT:   max_limit_r   <= cfg_data;
        ahap_pkg::CFG_MEAN_LIMIT:  mean_limit_r  <= cfg_data;
        ahap_pkg::CFG_FIRST_LAYER: first_layer_r <= cfg_data[ahap_pkg::LAYER_W-1:0];
        ahap_pkg::CFG_LAST_LAYER:  last_layer_r  <= cfg_data[ahap_pkg::LAYER_W-1:0];
        default: ;
      endcase
    end
  end

  ahap_div u_div (
    .clk      (clk),
    .load     (cmd.div_load),
    .step     (cmd.div_step),
    .dividend (sum_r),
    .divisor  (cnt_r),
    .quotient (quotient)
  );

  always_comb begin
    if (peak_r > max_limit_r) begin
      kind = ahap_pkg::KIND_MAX;
    end else if (quotient > mean_limit_r) begin
      kind = ahap_pkg::KIND_MEAN;
    end else begin
      kind = ahap_pkg::KIND_NORMAL;
    end
  end

  always_comb begin
    peak_nxt      = peak_r;
    sum_nxt       = sum_r;
    cnt_nxt       = cnt_r;
    probed_nxt    = probed_r;
    anom_nxt      = anom_r;
    out_valid_nxt = out_valid_r && out_stall;
    // past the element cap the head keeps its stats but can still close
    if (cmd.acc_en && (cnt_r < ahap_pkg::CNT_W'(ahap_pkg::MAX_HEAD_ELEMENTS))) begin
      if (wclip > peak_r) begin
        peak_nxt = wclip;
      end
      sum_nxt = sum_r + ahap_pkg::SUM_W'(wclip);
      cnt_nxt = cnt_r + 1'b1;
    end
    if (cmd.clr_stats) begin
      probed_nxt = '0;
      anom_nxt   = '0;
    end
    if (cmd.out_load) begin
      peak_nxt      = '0;
      sum_nxt       = '0;
      cnt_nxt       = '0;
      out_valid_nxt = 1'b1;
      if (probed_r != '1) begin
        probed_nxt = probed_r + 1'b1;
      end
      if ((kind != ahap_pkg::KIND_NORMAL) && (anom_r != '1)) begin
        anom_nxt = anom_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      peak_r      <= '0;
      sum_r       <= '0;
      cnt_r       <= '0;
      probed_r    <= '0;
      anom_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      peak_r      <= peak_nxt;
      sum_r       <= sum_nxt;
      cnt_r       <= cnt_nxt;
      probed_r    <= probed_nxt;
      anom_r      <= anom_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.acc_en && in_head_end) begin
      tag_layer_r <= in_layer_index;
      tag_head_r  <= in_head_index;
    end
    if (cmd.out_load) begin
      out_layer          <= tag_layer_r;
      out_head           <= tag_head_r;
      out_peak_weight    <= peak_r;
      out_average_weight <= quotient;
      out_anomaly_kind   <= kind;
      out_probed_total   <= probed_nxt;
      out_anomaly_total  <= anom_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

@@ rtl/core/ahap_checker.sv @@
// Port-level checker for the attention head anomaly probe, with its bind.
`include "assert_macros.svh"

module ahap_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            out_valid,
  input logic                            out_stall,
  input logic [ahap_pkg::WGT_W-1:0]      out_peak_weight,
  input logic [ahap_pkg::WGT_W-1:0]      out_average_weight,
  input logic [ahap_pkg::KIND_W-1:0]     out_anomaly_kind,
  input logic [ahap_pkg::TOT_W-1:0]      out_probed_total,
  input logic [ahap_pkg::TOT_W-1:0]      out_anomaly_total
);

  // a stalled result word stays valid and holds its peak, mean and probed total
  `AHAP_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_peak_weight) && $stable(out_average_weight) && $stable(out_probed_total))

  // floor mean never exceeds the head maximum
  `AHAP_ASSERT_IMP(a_mean_le_peak, clk, rst_n, out_valid, out_average_weight <= out_peak_weight)

  // anomalies are a subset of probed heads
  `AHAP_ASSERT_IMP(a_anom_le_probed, clk, rst_n, out_valid, out_anomaly_total <= out_probed_total)

  // an anomalous head is counted in the reported total
  `AHAP_ASSERT_IMP(a_anom_counted, clk, rst_n, out_valid && (out_anomaly_kind != ahap_pkg::KIND_NORMAL), out_anomaly_total != '0)

  // every result counts at least its own head
  `AHAP_ASSERT_IMP(a_probed_nonzero, clk, rst_n, out_valid, out_probed_total != '0)

endmodule

bind attention_head_anomaly_probe ahap_checker u_ahap_checker (.*);
